FILE: design/bec_pkg.sv
package bec_pkg;

  localparam int unsigned DefFracBits = 16;
  localparam int unsigned PortFrac    = 16;
  localparam int unsigned PortW       = 17;
  localparam int unsigned LimitW      = 7;
  localparam int unsigned TolW        = 16;
  localparam int unsigned LimitMax    = 64;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 16;

  localparam logic [CfgIdxW-1:0] RegIterLimit = 1'b0;
  localparam logic [CfgIdxW-1:0] RegTolerance = 1'b1;

  typedef struct packed {
    logic [PortW-1:0] x_in;
    logic [PortW-1:0] first_ctrl_x;
    logic [PortW-1:0] first_ctrl_y;
    logic [PortW-1:0] second_ctrl_x;
    logic [PortW-1:0] second_ctrl_y;
  } bec_in_t;

  typedef struct packed {
    logic [PortW-1:0] y_out;
    logic             converged;
  } bec_out_t;

  // control handed from the sequencer to each cell
  typedef struct packed {
    logic load;
    logic shift;
  } bec_ctl_t;

endpackage

FILE: design/bec_mul.sv
// one signed q2 product per cycle, rounded magnitude, saturated, registered
module bec_mul #(
  parameter int unsigned FracBits = bec_pkg::DefFracBits
) (
  input  logic                       clk_i,
  input  logic signed [FracBits+2:0] a_i,
  input  logic signed [FracBits+2:0] b_i,
  output logic signed [FracBits+2:0] p_o
);
  import bec_pkg::*;
  localparam int unsigned W  = FracBits + 3;
  localparam int unsigned PW = 2 * W;

  logic          neg;
  logic [W-1:0]  ua, ub;
  logic [PW-1:0] prod, rnd;
  logic [PW-1:0] mag;
  logic signed [PW:0] sv;
  logic signed [W-1:0] hi, lo;
  logic signed [W-1:0] p_d, p_q;

  always_comb begin
    neg  = a_i[W-1] ^ b_i[W-1];
    ua   = a_i[W-1] ? W'(-a_i) : W'(a_i);
    ub   = b_i[W-1] ? W'(-b_i) : W'(b_i);
    prod = PW'(ua) * PW'(ub);
    rnd  = prod + (PW'(1) << (FracBits - 1));
    mag  = rnd >> FracBits;
    sv   = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    hi   = {1'b0, {(W-1){1'b1}}};
    lo   = {1'b1, {(W-1){1'b0}}};
    if (sv > (PW+1)'(hi))      p_d = hi;
    else if (sv < (PW+1)'(lo)) p_d = lo;
    else                       p_d = W'(sv);
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end
  assign p_o = p_q;
endmodule

FILE: design/bec_cell.sv
// one slot of the operand chain: loads a value or takes its neighbor's
module bec_cell #(
  parameter int unsigned FracBits = bec_pkg::DefFracBits
) (
  input  logic                       clk_i,
  input  bec_pkg::bec_ctl_t          ctl_i,
  input  logic signed [FracBits+2:0] load_i,
  input  logic signed [FracBits+2:0] prev_i,
  output logic signed [FracBits+2:0] val_o
);
  import bec_pkg::*;
  logic signed [FracBits+2:0] v_d, v_q;
  always_comb begin
    v_d = v_q;
    if (ctl_i.load)       v_d = load_i;
    else if (ctl_i.shift) v_d = prev_i;
  end
  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end
  assign val_o = v_q;
endmodule

FILE: design/bezier_easing_curve_eval.sv
// bezier easing y from x: one transaction in flight at a time
// the diagonal shortcut skips the search; otherwise the search ends when the
//   step limit n is reached (n capped at 64) or when a residual test meets
//   the tolerance
// a new start is taken only when idle, also in the strobe cycle; the shared
//   multiplier steps through the products one after another
// reset clears control state and sets the registers to limit 16, tolerance 33
// result strobe lasts one cycle; the receiver cannot stall
module bezier_easing_curve_eval #(
  parameter int unsigned FracBits = bec_pkg::DefFracBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  bec_pkg::bec_in_t               in_i,
  output logic                           done_o,
  output bec_pkg::bec_out_t              out_o,
  input  logic                           cfg_we_i,
  input  logic [bec_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bec_pkg::CfgDataW-1:0]   cfg_data_i
);
  import bec_pkg::*;

  localparam int unsigned W  = FracBits + 3;
  localparam int unsigned EW = W + 4;   // headroom for sums of a few terms
  localparam int unsigned NCells = 2;

  typedef enum logic [7:0] {
    StIdle  = 8'b0000_0001,
    StPrep  = 8'b0000_0010,
    StSq    = 8'b0000_0100,
    StCube  = 8'b0000_1000,
    StTerms = 8'b0001_0000,
    StCheck = 8'b0010_0000,
    StY     = 8'b0100_0000,
    StOut   = 8'b1000_0000
  } state_e;

  // ---------------------------------------------------------------- helpers
  function automatic logic signed [W-1:0] sat(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] hi, lo;
    hi = EW'({1'b0, {(W-1){1'b1}}});
    lo = -(EW'(1) <<< (W-1));
    if (v > hi)      sat = {1'b0, {(W-1){1'b1}}};
    else if (v < lo) sat = {1'b1, {(W-1){1'b0}}};
    else             sat = W'(v);
  endfunction

  function automatic logic signed [W-1:0] to_int(input logic [PortW-1:0] p);
    logic [W+PortW-1:0] e;
    e = (W+PortW)'(p);
    if (FracBits >= PortFrac) to_int = W'(e << (FracBits - PortFrac));
    else                      to_int = W'(e >> (PortFrac - FracBits));
  endfunction

  // --------------------------------------------------------- config regs
  logic [LimitW-1:0] limit_q;
  logic [TolW-1:0]   tol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitW'(16);
      tol_q   <= TolW'(33);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegIterLimit: limit_q <= cfg_data_i[LimitW-1:0];
        RegTolerance: tol_q   <= cfg_data_i[TolW-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ datapath
  state_e state_q, state_d;
  logic [2:0] sub_q, sub_d;           // sub-step within a phase
  logic [LimitW-1:0] cnt_q, cnt_d;
  logic conv_q, conv_d;
  logic diag_q, diag_d;

  logic signed [W-1:0] x_q, ay_q, by_q, k0_q, k1_q, k2_q, t_q, tol_i_q;
  logic signed [W-1:0] x_d, ay_d, by_d, k0_d, k1_d, k2_d, t_d, tol_i_d;
  logic signed [EW-1:0] acc_q, acc_d;
  logic [PortW-1:0] xr_q, xr_d;
  bec_out_t res_q, res_d;
  logic done_q, done_d;

  // operand chain: cell0 <- product, cell1 <- cell0
  // holds the latest two products (t2, t3, ...)
  bec_ctl_t ctl;
  logic signed [W-1:0] cell_v [NCells];
  logic signed [W-1:0] mul_a, mul_b, mul_p;

  bec_mul #(.FracBits(FracBits)) u_mul (
    .clk_i (clk_i), .a_i(mul_a), .b_i(mul_b), .p_o(mul_p)
  );

  for (genvar g = 0; g < NCells; g++) begin : g_cell
    bec_cell #(.FracBits(FracBits)) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .load_i (mul_p),
      .prev_i ((g == 0) ? mul_p : cell_v[(g == 0) ? 0 : g-1]),
      .val_o  (cell_v[g])
    );
  end

  logic [LimitW-1:0] lim_eff;
  assign lim_eff = (limit_q > LimitW'(LimitMax)) ? LimitW'(LimitMax) : limit_q;

  logic signed [W-1:0] r_val;
  logic signed [EW-1:0] one_e;
  assign one_e = EW'(1) <<< FracBits;
  assign r_val = sat(one_e - EW'(t_q));

  logic signed [W-1:0] f_val;
  assign f_val = sat(acc_q);

  // products of one step: sq issues t*t, cube issues t2*t, terms 0..2 issue
  // k0*t3, k1*t2, k2*t, terms 3 closes the sum
  // y phase reuses the same scheme with its own product order
  logic [PortW-1:0] yport;
  logic signed [W-1:0] ysat;

  always_comb begin
    state_d = state_q; sub_d = sub_q; cnt_d = cnt_q; conv_d = conv_q;
    diag_d = diag_q;
    x_d = x_q; ay_d = ay_q; by_d = by_q; k0_d = k0_q; k1_d = k1_q; k2_d = k2_q;
    t_d = t_q; tol_i_d = tol_i_q; acc_d = acc_q; xr_d = xr_q;
    res_d = res_q; done_d = 1'b0;
    mul_a = t_q; mul_b = t_q;
    ctl = '{load: 1'b0, shift: 1'b0};
    yport = '0; ysat = '0;

    unique case (state_q)
      StIdle: begin
        if (start) begin
          xr_d   = in_i.x_in;
          diag_d = (in_i.first_ctrl_x == in_i.first_ctrl_y) &&
                   (in_i.second_ctrl_x == in_i.second_ctrl_y);
          x_d  = to_int(in_i.x_in);
          ay_d = to_int(in_i.first_ctrl_y);
          by_d = to_int(in_i.second_ctrl_y);
          k2_d = sat(EW'(3) * EW'(to_int(in_i.first_ctrl_x)));
          k1_d = sat(EW'(3) * EW'(to_int(in_i.second_ctrl_x))
                     - EW'(6) * EW'(to_int(in_i.first_ctrl_x)));
          k0_d = sat(one_e + EW'(3) * EW'(to_int(in_i.first_ctrl_x))
                     - EW'(3) * EW'(to_int(in_i.second_ctrl_x)));
          tol_i_d = to_int({1'b0, tol_q});
          t_d    = sat(EW'(to_int(in_i.x_in)));
          cnt_d  = '0;
          conv_d = 1'b0;
          state_d = StPrep;
        end
      end
      StPrep: begin
        sub_d = '0;
        if (diag_q) begin
          res_d.y_out = (xr_q > PortW'(65536)) ? PortW'(65536) : xr_q;
          res_d.converged = 1'b1;
          state_d = StOut;
        end else if (cnt_q == lim_eff) begin
          state_d = StY;
        end else begin
          state_d = StSq;
        end
      end
      StSq: begin
        // issue t*t, product lands next cycle
        mul_a = t_q; mul_b = t_q;
        state_d = StCube;
      end
      StCube: begin
        // t2 into chain, issue t2*t
        ctl.shift = 1'b1;
        mul_a = mul_p; mul_b = t_q;
        state_d = StTerms; sub_d = '0;
      end
      StTerms: begin
        // chain: cell0=t3 (after sub0 shift), cell1=t2
        unique case (sub_q)
          3'd0: begin
            ctl.shift = 1'b1;
            mul_a = k0_q; mul_b = mul_p;       // k0*t3
            sub_d = 3'd1;
          end
          3'd1: begin
            mul_a = k1_q; mul_b = cell_v[1];   // k1*t2
            acc_d = EW'(mul_p);
            sub_d = 3'd2;
          end
          3'd2: begin
            mul_a = k2_q; mul_b = t_q;         // k2*t
            acc_d = acc_q + EW'(mul_p);
            sub_d = 3'd3;
          end
          3'd3: begin
            acc_d = acc_q + EW'(mul_p) - EW'(x_q);
            sub_d = '0;
            state_d = StCheck;
          end
          default: sub_d = '0;
        endcase
      end
      StCheck: begin
        if (f_val <= tol_i_q && f_val >= -tol_i_q) begin
          conv_d = 1'b1;
          state_d = StY;
        end else begin
          t_d = sat(EW'(t_q) - EW'(f_val / 2));
          cnt_d = cnt_q + 1'b1;
          state_d = StPrep;
        end
        sub_d = '0;
      end
      StY: begin
        // y = t3 + 3*(t2*r)*by + 3*(t*(r*r))*ay
        unique case (sub_q)
          3'd0: begin mul_a = t_q; mul_b = t_q; sub_d = 3'd1; end
          3'd1: begin
            ctl.shift = 1'b1;                    // cell0 = t2
            mul_a = mul_p; mul_b = t_q; sub_d = 3'd2;
          end
          3'd2: begin
            ctl.shift = 1'b1;                    // cell0 = t3, cell1 = t2
            mul_a = r_val; mul_b = r_val; sub_d = 3'd3;
          end
          3'd3: begin
            ctl.shift = 1'b1;                    // cell0 = r2, cell1 = t3
            mul_a = cell_v[1]; mul_b = r_val;    // t2*r
            acc_d = EW'(cell_v[0]);              // t3
            sub_d = 3'd4;
          end
          3'd4: begin
            mul_a = t_q; mul_b = cell_v[0];      // t*r2
            acc_d = acc_q;
            ctl.shift = 1'b1;                    // cell0 = t2r
            sub_d = 3'd5;
          end
          3'd5: begin
            mul_a = cell_v[0]; mul_b = by_q;     // t2r*by
            ctl.shift = 1'b1;                    // cell0 = t r2
            sub_d = 3'd6;
          end
          3'd6: begin
            mul_a = cell_v[0]; mul_b = ay_q;     // tr2*ay
            acc_d = acc_q + EW'(3) * EW'(mul_p);
            sub_d = 3'd7;
          end
          3'd7: begin
            acc_d = acc_q + EW'(3) * EW'(mul_p);
            sub_d = '0;
            state_d = StOut;
          end
          default: sub_d = '0;
        endcase
      end
      StOut: begin
        if (!diag_q) begin
          // negative or zero y gives zero
          if (acc_q[EW-1] || acc_q == '0) yport = '0;
          else if (acc_q >= one_e) yport = PortW'(65536);
          else begin
            ysat = W'(acc_q);
            if (FracBits > PortFrac)
              yport = PortW'((EW'(ysat) + (EW'(1) <<< (FracBits - PortFrac - 1)))
                             >>> (FracBits - PortFrac));
            else
              yport = PortW'(EW'(ysat) <<< (PortFrac - FracBits));
          end
          res_d.y_out = yport;
          res_d.converged = conv_q;
        end
        done_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // note: in StTerms sub1 cell_v[1] is t2 since StCube and sub0 both shifted

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sub_q   <= '0;
      cnt_q   <= '0;
      conv_q  <= 1'b0;
      diag_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sub_q   <= sub_d;
      cnt_q   <= cnt_d;
      conv_q  <= conv_d;
      diag_q  <= diag_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; ay_q <= ay_d; by_q <= by_d;
    k0_q <= k0_d; k1_q <= k1_d; k2_q <= k2_d;
    t_q <= t_d; tol_i_q <= tol_i_d; acc_q <= acc_d; xr_q <= xr_d;
    res_q <= res_d;
  end

  assign busy   = (state_q != StIdle);
  assign done_o = done_q;
  assign out_o  = res_q;

  // ---------------------------------------------------------- assertions
  a_done_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == StOut)) else $error("strobe without finish");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("transaction not taken");
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LimitW'(LimitMax)) else $error("step count overrun");
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> out_o.y_out <= PortW'(65536)) else $error("y out of range");

endmodule

FILE: tb/tb_bezier_easing_curve_eval.sv
module tb_bezier_easing_curve_eval;
  timeunit 1ns;
  timeprecision 1ps;

  import bec_pkg::*;

  localparam int FB = 16;
  localparam longint QHI = (longint'(4) << FB) - 1;
  localparam longint QLO = -(longint'(4) << FB);
  localparam longint ONE = longint'(1) << FB;
  // watchdog bound with plenty of slack over the longest transaction
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  bec_in_t in_i = '0;
  logic done_o;
  bec_out_t out_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = RegIterLimit;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  bezier_easing_curve_eval dut (.*);

  always #2 clk_i = ~clk_i;

  // shadow copy of the two registers
  logic [LimitW-1:0] cur_limit = 7'd16;
  logic [TolW-1:0] cur_tol = 16'd33;

  bec_out_t curve_results_q[$];
  int mismatches = 0;
  int watchdog = 0;
  bit idle_free = 1'b0;

  // saturate to the internal signed Q2 range
  function automatic longint clamp_q2(longint v);
    if (v > QHI) return QHI;
    if (v < QLO) return QLO;
    return v;
  endfunction

  // fixed-point product, magnitude rounded half away from zero
  function automatic longint qmul(longint a, longint b);
    longint ua, ub, r;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    r = (ua * ub + (longint'(1) << (FB - 1))) >>> FB;
    return clamp_q2(neg ? -r : r);
  endfunction

  function automatic bec_out_t predict_ease(bec_in_t it);
    bec_out_t res;
    longint x, ax, ay, bx, by, k0, k1, k2, t, tol, t2, t3, r, y, f;
    int lim;
    res = '0;
    // diagonal control points: y is x itself
    if (it.first_ctrl_x == it.first_ctrl_y && it.second_ctrl_x == it.second_ctrl_y) begin
      res.y_out = it.x_in > 17'd65536 ? 17'd65536 : it.x_in;
      res.converged = 1'b1;
      return res;
    end
    x = it.x_in;
    ax = it.first_ctrl_x;
    ay = it.first_ctrl_y;
    bx = it.second_ctrl_x;
    by = it.second_ctrl_y;
    tol = cur_tol;
    k0 = clamp_q2(ONE + 3 * ax - 3 * bx);
    k1 = clamp_q2(3 * bx - 6 * ax);
    k2 = clamp_q2(3 * ax);
    t = clamp_q2(x);
    lim = cur_limit > LimitMax ? LimitMax : cur_limit;
    for (int i = 0; i < lim; i++) begin
      t2 = qmul(t, t);
      t3 = qmul(t2, t);
      f = clamp_q2(qmul(k0, t3) + qmul(k1, t2) + qmul(k2, t) - x);
      if (f <= tol && f >= -tol) begin
        res.converged = 1'b1;
        break;
      end
      // halving truncates toward zero
      t = clamp_q2(t - f / 2);
    end
    r = clamp_q2(ONE - t);
    t2 = qmul(t, t);
    t3 = qmul(t2, t);
    y = t3 + 3 * qmul(qmul(t2, r), by) + 3 * qmul(qmul(t, qmul(r, r)), ay);
    if (y <= 0) res.y_out = '0;
    else if (y >= ONE) res.y_out = 17'd65536;
    else res.y_out = y[16:0];
    return res;
  endfunction

  // result checker: every strobe must match the oldest expectation
  always @(posedge clk_i) begin
    bec_out_t want;
    if (rst_ni && done_o) begin
      if (curve_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result y=%0d conv=%0b",
                                       out_o.y_out, out_o.converged);
      end else begin
        want = curve_results_q.pop_front();
        if (want.y_out !== out_o.y_out || want.converged !== out_o.converged) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected y=%0d conv=%0b, got y=%0d conv=%0b",
                     want.y_out, want.converged, out_o.y_out, out_o.converged);
        end
      end
    end
  end

  // watchdog on cycles with no accepted transaction and no result
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) watchdog <= 0;
    else watchdog <= watchdog + 1;
    if (watchdog >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // start stays high after a transaction until the next call decides
  task automatic send_curve(bec_in_t it);
    // random idle gaps on the sender side
    while (!idle_free && $urandom_range(99) < 13) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    // accepted at this edge; predict with the settings in force
    curve_results_q.push_back(predict_ease(it));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (curve_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegIterLimit) cur_limit = val[LimitW-1:0];
    else cur_tol = val;
  endtask

  function automatic logic [16:0] rand_coord();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(131071));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  function automatic bec_in_t rand_item();
    bec_in_t it;
    it.x_in = rand_coord();
    it.first_ctrl_x = rand_coord();
    it.first_ctrl_y = rand_coord();
    it.second_ctrl_x = rand_coord();
    it.second_ctrl_y = rand_coord();
    // sometimes force the diagonal shortcut
    if ($urandom_range(15) == 0) begin
      it.first_ctrl_y = it.first_ctrl_x;
      it.second_ctrl_y = it.second_ctrl_x;
    end
    return it;
  endfunction

  task automatic test_directed();
    bec_in_t it;
    // diagonal shortcut, including x above 1.0
    it = '{17'd30000, 17'd1000, 17'd1000, 17'd50000, 17'd50000};
    send_curve(it);
    it.x_in = 17'h1FFFF;
    send_curve(it);
    // standard ease curve at ends and middle
    it = '{17'd0, 17'd16384, 17'd0, 17'd39322, 17'd65536};
    send_curve(it);
    it.x_in = 17'd32768;
    send_curve(it);
    it.x_in = 17'd65536;
    send_curve(it);
    // fields at the extremes of their range
    it = '{17'h1FFFF, 17'h1FFFF, 17'h0, 17'h1FFFF, 17'h10000};
    send_curve(it);
    it = '{17'h1FFFF, 17'h0, 17'h1FFFF, 17'h0, 17'h1FFFF};
    send_curve(it);
    it = '{17'h15555, 17'h0AAAA, 17'h15555, 17'h0AAAA, 17'h15555};
    send_curve(it);
  endtask

  task automatic test_limits();
    // zero limit: no steps, never converged
    write_reg(RegIterLimit, 16'd0);
    send_curve('{17'd20000, 17'd16384, 17'd0, 17'd39322, 17'd65536});
    // limit above 64 is capped
    write_reg(RegIterLimit, 16'd127);
    write_reg(RegTolerance, 16'd0);
    send_curve('{17'd20000, 17'd16384, 17'd0, 17'd39322, 17'd65536});
    write_reg(RegTolerance, 16'd65535);
    write_reg(RegIterLimit, 16'd64);
    send_curve('{17'd20000, 17'd16384, 17'd0, 17'd39322, 17'd65536});
  endtask

  task automatic test_random_phase(int n, logic [CfgDataW-1:0] lim, logic [CfgDataW-1:0] tol);
    write_reg(RegIterLimit, lim);
    write_reg(RegTolerance, tol);
    for (int i = 0; i < n; i++) begin
      // a stretch with no idling in the middle of each phase
      idle_free = (i >= n / 3) && (i < n / 2);
      send_curve(rand_item());
    end
    idle_free = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_limits();
    test_random_phase(500, 16'd16, 16'd33);
    test_random_phase(300, 16'd1, 16'd0);
    test_random_phase(300, 16'd64, 16'd0);
    test_random_phase(300, 16'($urandom_range(127)), 16'($urandom_range(65535)));
    test_random_phase(300, 16'd8, 16'd200);
    test_random_phase(300, 16'd0, 16'd33);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && curve_results_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/bec_pkg.sv
design/bec_mul.sv
design/bec_cell.sv
design/bezier_easing_curve_eval.sv
tb/tb_bezier_easing_curve_eval.sv
